### rtl/core/msvf_pkg.sv
// Shared types, constants and functions of the modulated state-variable filter.
// Holds the microcode program, the control word layout and the exp2 table math.
// No dependencies; every other file refers to it by scoped names.
package msvf_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int EXP_DEPTH_DEF    = 64;

    // Datapath widths
    localparam int ACC_W      = 32;   // saturated state and working values
    localparam int WIDE_W     = 36;   // headroom for sums before saturation
    localparam int SUM_W      = 34;   // sum of two band values
    localparam int MUL_A_W    = 17;   // coefficient operand, signed
    localparam int MUL_B_W    = 33;   // state / control operand, signed
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int EXP_FRAC_W = 28;   // fraction bits of the exponent product
    localparam int COEF_W     = 15;
    localparam int MOD_W      = 16;
    localparam int ENTRY_W    = 16;
    localparam int SHIFT_W    = 5;

    // ln 2 in Q30
    localparam logic [63:0] LN2_Q30 = 64'd744261118;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_COEF    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_DEPTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COEF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COEF     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING      = 3'd5;

    typedef enum logic [1:0] {
        BAND_PASS = 2'd0,
        BAND_LOW  = 2'd1,
        BAND_HIGH = 2'd2,
        BAND_BP   = 2'd3
    } t_band;

    typedef struct packed {
        t_band                band_mode;
        logic [COEF_W-1:0]    base_coef;
        logic [MOD_W-1:0]     octave_depth;
        logic [COEF_W-1:0]    key_coef;
        logic [COEF_W-1:0]    max_coef;
        logic [COEF_W-1:0]    damping;
    } t_cfg;

    localparam logic [COEF_W-1:0] RST_BASE_COEF    = 15'd513;
    localparam logic [MOD_W-1:0]  RST_OCTAVE_DEPTH = 16'd8192;
    localparam logic [COEF_W-1:0] RST_KEY_COEF     = 15'd7613;
    localparam logic [COEF_W-1:0] RST_MAX_COEF     = 15'd19261;
    localparam logic [COEF_W-1:0] RST_DAMPING      = 15'd23406;

    // Microcode
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_EXP,     // octave_depth * mod_control
        MUL_SCALE,   // base_coef * exp2 entry
        MUL_FB,      // coef * bandpass
        MUL_DB,      // damping * bandpass
        MUL_FH       // coef * highpass
    } t_mul;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_INDEX,   // split exponent into shift and table index
        ALU_COEF,    // shift, add key coefficient, clamp
        ALU_LOW,     // lowpass update
        ALU_HIGH,    // highpass
        ALU_BAND     // bandpass update and band sum
    } t_alu;

    typedef enum logic [1:0] {
        BR_NEXT,     // fall through
        BR_BYPASS,   // jump to target in pass mode
        BR_LOOP,     // jump to target once, for the second filter pass
        BR_OUT       // wait for the output register, then retire
    } t_br;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_EXP    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_INDEX  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LOOKUP = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SCALE  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_COEF   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_FB     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_LOW    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_HIGH   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_FH     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_BAND   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_OUT    = 4'd10;

    typedef struct packed {
        t_mul              mul;
        t_alu              alu;
        t_br               br;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Decoded operation handed from the sequencer to the datapath
    typedef struct packed {
        t_mul mul;
        t_alu alu;
        logic second;   // second filter pass: feed the raw input
        logic commit;   // result leaves, filter state advances
    } t_uop;

    typedef struct packed {
        logic bypass;
        logic out_free;
    } t_stat;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{mul: MUL_NONE, alu: ALU_NONE, br: BR_NEXT, target: STEP_EXP};
        case (step)
            STEP_EXP: begin
                w.mul = MUL_EXP;
                w.br = BR_BYPASS;
                w.target = STEP_OUT;
            end
            STEP_INDEX:  w.alu = ALU_INDEX;
            STEP_LOOKUP: w.alu = ALU_NONE;
            STEP_SCALE:  w.mul = MUL_SCALE;
            STEP_COEF:   w.alu = ALU_COEF;
            STEP_FB:     w.mul = MUL_FB;
            STEP_LOW: begin
                w.mul = MUL_DB;
                w.alu = ALU_LOW;
            end
            STEP_HIGH:   w.alu = ALU_HIGH;
            STEP_FH:     w.mul = MUL_FH;
            STEP_BAND: begin
                w.alu = ALU_BAND;
                w.br = BR_LOOP;
                w.target = STEP_FB;
            end
            STEP_OUT:    w.br = BR_OUT;
            default:     w.br = BR_OUT;
        endcase
        return w;
    endfunction

    // 2^(y / 2^30 / ln2) in Q1.15 by Taylor series, y = k * ln2 / depth in Q30.
    // Only evaluated on constants at elaboration.
    function automatic logic [ENTRY_W-1:0] exp_series(input logic [63:0] y);
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] v;
        term = 64'd1 << 30;
        acc  = term;
        for (int n = 1; n <= 30; n++) begin
            term = ((term * y) >> 30) / 64'(n);
            acc  = acc + term;
        end
        v = (acc + (64'd1 << 14)) >> 15;
        if (v > 64'd65535)
            v = 64'd65535;
        return v[ENTRY_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = 36'sd2147483647;
        lo = -36'sd2147483648;
        if (v > hi)
            return 32'sh7FFFFFFF;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[ACC_W-1:0];
    endfunction

endpackage

### rtl/core/msvf_exp_rom.sv
// Constant exp2 fraction table with registered read.
// Entries are built at elaboration with msvf_pkg::exp_series.
module msvf_exp_rom #(
    parameter int EXP_TABLE_DEPTH = msvf_pkg::EXP_DEPTH_DEF,
    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH)
) (
    input  logic                           i_clk,
    input  logic [IDX_W-1:0]               i_idx,
    output logic [msvf_pkg::ENTRY_W-1:0]   o_entry
);

    logic [msvf_pkg::ENTRY_W-1:0] w_rom [EXP_TABLE_DEPTH];
    logic [msvf_pkg::ENTRY_W-1:0] r_entry;

    for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] Y = (64'(k) * msvf_pkg::LN2_Q30) / 64'(EXP_TABLE_DEPTH);
        assign w_rom[k] = msvf_pkg::exp_series(Y);
    end

    always_ff @(posedge i_clk) begin
        r_entry <= w_rom[i_idx];
    end

    assign o_entry = r_entry;

endmodule

### rtl/core/msvf_datapath.sv
// Datapath of the filter: one shared multiplier, a small ALU and the filter state.
// Driven one operation per cycle by msvf_useq; uses msvf_pkg and msvf_exp_rom.
module msvf_datapath #(
    parameter int SAMPLE_WIDTH    = msvf_pkg::SAMPLE_WIDTH_DEF,
    parameter int EXP_TABLE_DEPTH = msvf_pkg::EXP_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample_in,
    input  logic signed [msvf_pkg::MOD_W-1:0] i_mod_control,
    input  msvf_pkg::t_cfg                    i_cfg,
    input  msvf_pkg::t_uop                    i_uop,
    output logic signed [SAMPLE_WIDTH-1:0]    o_result
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int ACC_W  = msvf_pkg::ACC_W;
    localparam int WIDE_W = msvf_pkg::WIDE_W;
    localparam int SUM_W  = msvf_pkg::SUM_W;
    localparam int PROD_W = msvf_pkg::PROD_W;
    localparam int FW     = msvf_pkg::EXP_FRAC_W;
    localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
    localparam int COEF_W = msvf_pkg::COEF_W;
    localparam logic signed [SUM_W-1:0] S_MAX =
        SUM_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] S_MIN = -S_MAX - 34'sd1;

    logic signed [SW-1:0]                   r_x;
    logic signed [msvf_pkg::MOD_W-1:0]      r_mod;
    logic signed [SW-1:0]                   r_prev;
    logic signed [PROD_W-1:0]               r_prod;
    logic [IDX_W-1:0]                       r_idx;
    logic [msvf_pkg::SHIFT_W-1:0]           r_shift;
    logic [COEF_W-1:0]                      r_f;
    logic signed [ACC_W-1:0]                r_l;
    logic signed [ACC_W-1:0]                r_h;
    logic signed [ACC_W-1:0]                r_b;
    logic signed [SUM_W-1:0]                r_sum;

    logic signed [msvf_pkg::MUL_A_W-1:0]    w_mul_a;
    logic signed [msvf_pkg::MUL_B_W-1:0]    w_mul_b;
    logic signed [PROD_W-1:0]               w_mul_p;
    logic [msvf_pkg::ENTRY_W-1:0]           w_entry;

    // Multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_uop.mul)
            msvf_pkg::MUL_EXP: begin
                w_mul_a = {1'b0, i_cfg.octave_depth};
                w_mul_b = {{17{r_mod[15]}}, r_mod};
            end
            msvf_pkg::MUL_SCALE: begin
                w_mul_a = {2'b00, i_cfg.base_coef};
                w_mul_b = {17'd0, w_entry};
            end
            msvf_pkg::MUL_FB: begin
                w_mul_a = {2'b00, r_f};
                w_mul_b = {r_b[ACC_W-1], r_b};
            end
            msvf_pkg::MUL_DB: begin
                w_mul_a = {2'b00, i_cfg.damping};
                w_mul_b = {r_b[ACC_W-1], r_b};
            end
            msvf_pkg::MUL_FH: begin
                w_mul_a = {2'b00, r_f};
                w_mul_b = {r_h[ACC_W-1], r_h};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // Exponent split: top bits are the signed octave count, the rest the fraction
    logic [FW-1:0]                  w_frac;
    logic [FW+IDX_W:0]              w_frac_scaled;
    logic [5:0]                     w_shift6;

    assign w_frac        = r_prod[FW-1:0];
    assign w_frac_scaled = (FW+IDX_W+1)'(w_frac) * (FW+IDX_W+1)'(EXP_TABLE_DEPTH);
    assign w_shift6      = 6'd15 - {r_prod[FW+4], r_prod[FW+4:FW]};

    msvf_exp_rom #(
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_exp_rom (
        .i_clk   (i_clk),
        .i_idx   (r_idx),
        .o_entry (w_entry)
    );

    // Coefficient: scaled base, plus keyboard term, clamped from above
    logic [30:0]        w_scaled;
    logic [24:0]        w_msum;
    logic [COEF_W-1:0]  w_coef;

    assign w_scaled = r_prod[30:0] >> r_shift;
    assign w_msum   = {1'b0, w_scaled[23:0]} + 25'(i_cfg.key_coef);
    assign w_coef   = (w_msum > 25'(i_cfg.max_coef)) ? i_cfg.max_coef : w_msum[COEF_W-1:0];

    // Rounded products: add half, keep the high bits (floor)
    logic signed [PROD_W-1:0]   w_p15;
    logic signed [PROD_W-1:0]   w_p14;
    logic signed [PROD_W-16:0]  w_rnd15;
    logic signed [PROD_W-15:0]  w_rnd14;

    assign w_p15   = r_prod + PROD_W'(1 << 14);
    assign w_p14   = r_prod + PROD_W'(1 << 13);
    assign w_rnd15 = w_p15[PROD_W-1:15];
    assign w_rnd14 = w_p14[PROD_W-1:14];

    // Filter arithmetic
    logic signed [SW:0]         w_pair;
    logic signed [SW-1:0]       w_avg;
    logic signed [SW-1:0]       w_u;
    logic signed [ACC_W-1:0]    w_l_new;
    logic signed [ACC_W-1:0]    w_h_new;
    logic signed [ACC_W-1:0]    w_b_new;
    logic signed [ACC_W-1:0]    w_band;

    assign w_pair  = {r_x[SW-1], r_x} + {r_prev[SW-1], r_prev};
    assign w_avg   = w_pair[SW:1];
    assign w_u     = i_uop.second ? r_x : w_avg;
    assign w_l_new = msvf_pkg::sat32({{(WIDE_W-ACC_W){r_l[ACC_W-1]}}, r_l}
                                     + {w_rnd15[PROD_W-16], w_rnd15});
    assign w_h_new = msvf_pkg::sat32({{(WIDE_W-SW){w_u[SW-1]}}, w_u}
                                     - {{(WIDE_W-ACC_W){r_l[ACC_W-1]}}, r_l}
                                     - w_rnd14);
    assign w_b_new = msvf_pkg::sat32({{(WIDE_W-ACC_W){r_b[ACC_W-1]}}, r_b}
                                     + {w_rnd15[PROD_W-16], w_rnd15});

    always_comb begin
        case (i_cfg.band_mode)
            msvf_pkg::BAND_LOW:  w_band = r_l;
            msvf_pkg::BAND_HIGH: w_band = r_h;
            default:             w_band = w_b_new;
        endcase
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_sample_in;
            r_mod <= i_mod_control;
            r_sum <= '0;
        end
        if (i_uop.mul != msvf_pkg::MUL_NONE)
            r_prod <= w_mul_p;
        case (i_uop.alu)
            msvf_pkg::ALU_INDEX: begin
                r_idx   <= w_frac_scaled[FW+IDX_W-1:FW];
                r_shift <= w_shift6[msvf_pkg::SHIFT_W-1:0];
            end
            msvf_pkg::ALU_COEF: r_f <= w_coef;
            msvf_pkg::ALU_HIGH: r_h <= w_h_new;
            msvf_pkg::ALU_BAND: r_sum <= r_sum + {{(SUM_W-ACC_W){w_band[ACC_W-1]}}, w_band};
            default: ;
        endcase
    end

    // Filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_l    <= '0;
            r_b    <= '0;
        end else begin
            if (i_uop.alu == msvf_pkg::ALU_LOW)
                r_l <= w_l_new;
            if (i_uop.alu == msvf_pkg::ALU_BAND)
                r_b <= w_b_new;
            if (i_uop.commit && (i_cfg.band_mode != msvf_pkg::BAND_PASS))
                r_prev <= r_x;
        end
    end

    // Result: raw sample in pass mode, else the band sum saturated to sample range
    always_comb begin
        if (i_cfg.band_mode == msvf_pkg::BAND_PASS)
            o_result = r_x;
        else if (r_sum > S_MAX)
            o_result = S_MAX[SW-1:0];
        else if (r_sum < S_MIN)
            o_result = S_MIN[SW-1:0];
        else
            o_result = r_sum[SW-1:0];
    end

endmodule

### rtl/core/msvf_useq.sv
// Microcode sequencer: step counter, program lookup and branch logic.
// Program and control word layout come from msvf_pkg.
module msvf_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  msvf_pkg::t_stat i_stat,
    output msvf_pkg::t_uop  o_uop,
    output logic            o_busy
);

    localparam int STEP_W = msvf_pkg::STEP_W;

    logic               r_busy;
    logic               n_busy;
    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  n_step;
    logic               r_second;
    logic               n_second;
    msvf_pkg::t_uword   w_word;

    assign w_word = msvf_pkg::ucode(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= msvf_pkg::STEP_EXP;
            r_second <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_step   <= n_step;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_busy   = r_busy;
        n_step   = r_step;
        n_second = r_second;
        o_uop    = '{mul: msvf_pkg::MUL_NONE, alu: msvf_pkg::ALU_NONE,
                     second: r_second, commit: 1'b0};
        if (!r_busy) begin
            if (i_start) begin
                n_busy   = 1'b1;
                n_step   = msvf_pkg::STEP_EXP;
                n_second = 1'b0;
            end
        end else begin
            o_uop.mul = w_word.mul;
            o_uop.alu = w_word.alu;
            case (w_word.br)
                msvf_pkg::BR_NEXT: n_step = r_step + STEP_W'(1);
                msvf_pkg::BR_BYPASS: begin
                    n_step = i_stat.bypass ? w_word.target : r_step + STEP_W'(1);
                end
                msvf_pkg::BR_LOOP: begin
                    if (!r_second) begin
                        n_second = 1'b1;
                        n_step   = w_word.target;
                    end else begin
                        n_step = r_step + STEP_W'(1);
                    end
                end
                msvf_pkg::BR_OUT: begin
                    if (i_stat.out_free) begin
                        o_uop.commit = 1'b1;
                        n_busy       = 1'b0;
                    end
                end
                default: n_busy = 1'b0;
            endcase
        end
    end

    assign o_busy = r_busy;

endmodule

### rtl/core/modulated_state_variable_filter.sv
// Top level of the modulated state-variable filter (Chamberlin form, run twice a sample).
// Instantiates msvf_useq and msvf_datapath; types and constants from msvf_pkg.
//
// Usage:
//   Input channel: i_valid / o_stall with i_sample_in and i_mod_control. A transaction
//   is taken at a rising edge with i_valid high and o_stall low. One item is worked on
//   at a time; o_stall stays high while the sequencer is busy.
//   Output channel: o_valid / i_stall with o_sample_out, one transaction per input.
//   Configuration: write i_cfg_data to register i_cfg_index at an edge with i_cfg_we
//   high (0 band mode, 1 base coef, 2 octave depth, 3 key coef, 4 max coef, 5 damping).
//   Write only while the block is idle.
// Sequencing:
//   Filter modes run the whole microcode program, pass mode jumps from the first step
//   to the output step. The next item is taken only once the sequencer has retired the current one.
//   One step per cycle while not waiting in the output step; the five filter steps
//   run twice, and every product goes through the single shared 17x33 multiplier.
//   An item that waits in the output register does not hold up the next one.
// Reset (synchronous, active low): clear the filter state, load the register defaults.
// Receiver stall: the output register holds its transaction; a finished item then
//   waits in the last microcode step until the register frees up.
module modulated_state_variable_filter #(
    parameter int SAMPLE_WIDTH    = msvf_pkg::SAMPLE_WIDTH_DEF,
    parameter int EXP_TABLE_DEPTH = msvf_pkg::EXP_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample_in,
    input  logic signed [msvf_pkg::MOD_W-1:0]     i_mod_control,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        o_sample_out,
    input  logic                                  i_cfg_we,
    input  logic [msvf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [msvf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    msvf_pkg::t_cfg                 r_cfg;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data;

    logic                           w_busy;
    logic                           w_start;
    msvf_pkg::t_stat                w_stat;
    msvf_pkg::t_uop                 w_uop;
    logic signed [SAMPLE_WIDTH-1:0] w_result;

    // Configuration registers: write-only, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_mode    <= msvf_pkg::BAND_PASS;
            r_cfg.base_coef    <= msvf_pkg::RST_BASE_COEF;
            r_cfg.octave_depth <= msvf_pkg::RST_OCTAVE_DEPTH;
            r_cfg.key_coef     <= msvf_pkg::RST_KEY_COEF;
            r_cfg.max_coef     <= msvf_pkg::RST_MAX_COEF;
            r_cfg.damping      <= msvf_pkg::RST_DAMPING;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                msvf_pkg::CFG_BAND_MODE:    r_cfg.band_mode <= msvf_pkg::t_band'(i_cfg_data[1:0]);
                msvf_pkg::CFG_BASE_COEF:    r_cfg.base_coef    <= i_cfg_data[14:0];
                msvf_pkg::CFG_OCTAVE_DEPTH: r_cfg.octave_depth <= i_cfg_data;
                msvf_pkg::CFG_KEY_COEF:     r_cfg.key_coef     <= i_cfg_data[14:0];
                msvf_pkg::CFG_MAX_COEF:     r_cfg.max_coef     <= i_cfg_data[14:0];
                msvf_pkg::CFG_DAMPING:      r_cfg.damping      <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Accept a new item only while the sequencer is idle
    assign o_stall = w_busy;
    assign w_start = i_valid && !w_busy;

    assign w_stat.bypass   = (r_cfg.band_mode == msvf_pkg::BAND_PASS);
    assign w_stat.out_free = !r_out_valid || !i_stall;

    msvf_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_stat  (w_stat),
        .o_uop   (w_uop),
        .o_busy  (w_busy)
    );

    msvf_datapath #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_sample_in   (i_sample_in),
        .i_mod_control (i_mod_control),
        .i_cfg         (r_cfg),
        .i_uop         (w_uop),
        .o_result      (w_result)
    );

    // Output register: load on commit, drop once the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uop.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uop.commit)
            r_out_data <= w_result;
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_data;

endmodule
